@@ src/bfsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit frequency and serial counter package
// Shared field widths, operation codes and control types.
// ----------------------------------------------------------------------------
package bfsc_pkg;

    localparam int OPCODE_BITS   = 2;
    localparam int SAMPLE_BITS   = 32;
    localparam int INDEX_BITS    = 8;
    localparam int READ_BITS     = 32;
    localparam int MAX_WORD_BITS = 64;

    localparam int DEF_WORD_BITS  = 32;
    localparam int DEF_COUNT_BITS = 32;

    // The read select is split into a group number and a place in the group.
    localparam int GRP_SIZE     = 16;
    localparam int GRP_LO_BITS  = 4;
    localparam int GRP_SEL_BITS = INDEX_BITS - GRP_LO_BITS;
    localparam int MAX_GRPS     = 2 ** GRP_SEL_BITS;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_ACCUM = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef struct packed {
        logic accum;
        logic clear;
    } t_bank_ctrl;

endpackage

@@ src/bfsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit frequency and serial counter channels
// Valid/ready channels for the command items and the read results.
// ----------------------------------------------------------------------------
interface bfsc_in_if;
    import bfsc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [SAMPLE_BITS-1:0] sample_word;
    logic [INDEX_BITS-1:0]  counter_index;

    modport source (output valid, output opcode, output sample_word,
                    output counter_index, input ready);
    modport sink   (input valid, input opcode, input sample_word,
                    input counter_index, output ready);
endinterface

interface bfsc_out_if;
    import bfsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [READ_BITS-1:0] read_value;

    modport source (output valid, output read_value, input ready);
    modport sink   (input valid, input read_value, output ready);
endinterface

@@ src/bfsc_counter_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit frequency and serial counter bank
// Per-bit ones counters, per-bit pattern counters for non-overlapping word
// pairs, and the held earlier word of the open pair. All lanes update
// in parallel.
// ----------------------------------------------------------------------------
module bfsc_counter_bank #(
    parameter int WORD_BITS  = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bfsc_pkg::t_bank_ctrl   i_ctrl,
    input  logic [WORD_BITS-1:0]   i_word,
    output logic [COUNT_BITS-1:0]  o_ones  [WORD_BITS],
    output logic [COUNT_BITS-1:0]  o_pairs [4*WORD_BITS]
);
    import bfsc_pkg::*;

    logic [COUNT_BITS-1:0] r_ones  [WORD_BITS];
    logic [COUNT_BITS-1:0] n_ones  [WORD_BITS];
    logic [COUNT_BITS-1:0] r_pairs [4*WORD_BITS];
    logic [COUNT_BITS-1:0] n_pairs [4*WORD_BITS];
    logic [WORD_BITS-1:0]  r_held;
    logic [WORD_BITS-1:0]  n_held;
    logic                  r_phase;
    logic                  n_phase;

    always_comb begin
        n_ones  = r_ones;
        n_pairs = r_pairs;
        n_held  = r_held;
        n_phase = r_phase;
        if (i_ctrl.clear) begin
            n_ones  = '{default: '0};
            n_pairs = '{default: '0};
            n_held  = '0;
            n_phase = 1'b0;
        end else if (i_ctrl.accum) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                if (i_word[b] && !(&r_ones[b])) begin
                    n_ones[b] = r_ones[b] + 1'b1;
                end
            end
            if (!r_phase) begin
                n_held  = i_word;
                n_phase = 1'b1;
            end else begin
                // Pattern is earlier bit in the high place, later bit low.
                for (int b = 0; b < WORD_BITS; b++) begin
                    for (int p = 0; p < 4; p++) begin
                        if ({r_held[b], i_word[b]} == 2'(p) && !(&r_pairs[4*b+p])) begin
                            n_pairs[4*b+p] = r_pairs[4*b+p] + 1'b1;
                        end
                    end
                end
                n_phase = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ones  <= '{default: '0};
            r_pairs <= '{default: '0};
            r_held  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_ones  <= n_ones;
            r_pairs <= n_pairs;
            r_held  <= n_held;
            r_phase <= n_phase;
        end
    end

    assign o_ones  = r_ones;
    assign o_pairs = r_pairs;

endmodule

@@ src/bitwise_frequency_serial_counter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit frequency and serial counter, top level
// Counts ones per bit position and two-bit patterns per bit position over
// non-overlapping pairs of words; any counter can be read back.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the input is not stalled.
// Accumulate and clear items take effect in the cycle after they are accepted
// and give no result. A read item passes the command register, then the group
// select stage, which selects one candidate from each group of sixteen counters
// and registers it, then the output register, which picks the group. Reads
// always see every earlier accumulate and clear. The input stalls only when
// both read stages and the output register hold results the sink has not taken.
module bitwise_frequency_serial_counter_top #(
    parameter int WORD_BITS  = bfsc_pkg::DEF_WORD_BITS,
    parameter int COUNT_BITS = bfsc_pkg::DEF_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bfsc_in_if.sink           i_in,
    bfsc_out_if.source        o_out
);
    import bfsc_pkg::*;

    localparam int NUM_CNT  = 5 * WORD_BITS;
    localparam int GRP_RAW  = (NUM_CNT + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NUM_GRPS = (GRP_RAW > MAX_GRPS) ? MAX_GRPS : GRP_RAW;

    // Command register.
    logic                   r_s1_v;
    t_opcode                r_s1_op;
    logic [SAMPLE_BITS-1:0] r_s1_word;
    logic [INDEX_BITS-1:0]  r_s1_idx;

    // Group select stage.
    logic                    r_s2_v;
    logic [READ_BITS-1:0]    r_s2_grp_val [NUM_GRPS];
    logic [GRP_SEL_BITS-1:0] r_s2_grp;
    logic                    r_s2_hit;
    logic [READ_BITS-1:0]    n_s2_grp_val [NUM_GRPS];

    // Output register.
    logic                 r_o_v;
    logic [READ_BITS-1:0] r_o_val;
    logic [READ_BITS-1:0] n_o_val;

    logic s2_go;
    logic s2_free;
    logic s1_go;
    logic in_take;

    t_bank_ctrl              bank_ctrl;
    logic [MAX_WORD_BITS-1:0] word_ext;
    logic [WORD_BITS-1:0]    bank_word;
    logic [COUNT_BITS-1:0]   ones  [WORD_BITS];
    logic [COUNT_BITS-1:0]   pairs [4*WORD_BITS];
    logic [READ_BITS-1:0]    all_cnt [NUM_CNT];

    assign s2_go   = r_s2_v && (!r_o_v || o_out.ready);
    assign s2_free = !r_s2_v || s2_go;
    assign s1_go   = r_s1_v && ((r_s1_op != OP_READ) || s2_free);
    assign in_take = i_in.valid && i_in.ready;
    assign i_in.ready = !r_s1_v || s1_go;

    assign bank_ctrl.accum = s1_go && (r_s1_op == OP_ACCUM);
    assign bank_ctrl.clear = s1_go && (r_s1_op == OP_CLEAR);

    // Positions above the sample field see zero bits.
    assign word_ext  = {{(MAX_WORD_BITS-SAMPLE_BITS){1'b0}}, r_s1_word};
    assign bank_word = word_ext[WORD_BITS-1:0];

    bfsc_counter_bank #(
        .WORD_BITS  (WORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (bank_ctrl),
        .i_word  (bank_word),
        .o_ones  (ones),
        .o_pairs (pairs)
    );

    // Flat read map: ones counters first, then the pattern counters.
    always_comb begin
        logic [READ_BITS+COUNT_BITS-1:0] wide;
        for (int c = 0; c < NUM_CNT; c++) begin
            if (c < WORD_BITS) begin
                wide = {{READ_BITS{1'b0}}, ones[c]};
            end else begin
                wide = {{READ_BITS{1'b0}}, pairs[c-WORD_BITS]};
            end
            all_cnt[c] = wide[READ_BITS-1:0];
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GRPS; g++) begin
            n_s2_grp_val[g] = '0;
            for (int e = 0; e < GRP_SIZE; e++) begin
                if ((g*GRP_SIZE + e < NUM_CNT) &&
                    (r_s1_idx[GRP_LO_BITS-1:0] == GRP_LO_BITS'(e))) begin
                    n_s2_grp_val[g] = all_cnt[g*GRP_SIZE + e];
                end
            end
        end
    end

    always_comb begin
        n_o_val = '0;
        for (int g = 0; g < NUM_GRPS; g++) begin
            if (r_s2_hit && (r_s2_grp == GRP_SEL_BITS'(g))) begin
                n_o_val = r_s2_grp_val[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_v <= 1'b1;
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end
            if (s1_go && (r_s1_op == OP_READ)) begin
                r_s2_v <= 1'b1;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (s2_go) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_op   <= t_opcode'(i_in.opcode);
            r_s1_word <= i_in.sample_word;
            r_s1_idx  <= i_in.counter_index;
        end
        if (s1_go && (r_s1_op == OP_READ)) begin
            r_s2_grp_val <= n_s2_grp_val;
            r_s2_grp     <= r_s1_idx[INDEX_BITS-1:GRP_LO_BITS];
            r_s2_hit     <= ({1'b0, r_s1_idx} < (INDEX_BITS+1)'(NUM_CNT));
        end
        if (s2_go) begin
            r_o_val <= n_o_val;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.read_value = r_o_val;

endmodule

@@ sim/bitwise_frequency_serial_counter_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit frequency and serial counter testbench
// Sends accumulate, read, clear and unused-code items over the command
// channel. It keeps its own copy of the ones and pair counters, queues the
// value each read should return and compares every result in order. Both
// channels idle at random, and one long sink stall fills the read pipeline.
// ----------------------------------------------------------------------------
module bitwise_frequency_serial_counter_top_tb;
    import bfsc_pkg::*;

    localparam int  NUM_BITS      = DEF_WORD_BITS;
    localparam int  NUM_COUNTERS  = 5 * NUM_BITS;
    localparam int  ONES_IDX_BITS = $clog2(NUM_BITS);
    localparam int  PAIR_IDX_BITS = $clog2(4 * NUM_BITS);
    localparam int  DRAIN_CYCLES  = 8;
    localparam real RUN_LIMIT_NS  = 5_000_000.0;

    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [SAMPLE_BITS-1:0] sample_word;
        logic [INDEX_BITS-1:0]  counter_index;
    } t_cmd;

    logic i_clk;
    logic i_rst_n;

    bfsc_in_if  cmd_if ();
    bfsc_out_if rd_if ();

    bitwise_frequency_serial_counter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (rd_if)
    );

    // Local copy of the counter state.
    logic [31:0]          ones_cnt [NUM_BITS];
    logic [31:0]          pair_cnt [4*NUM_BITS];
    logic [NUM_BITS-1:0]  held_word;
    logic                 pair_open;

    logic [READ_BITS-1:0] expected_reads [$];
    logic [READ_BITS-1:0] want_value;

    int  fail_count;
    int  sink_hold_cycles;
    bit  send_idle_en;
    bit  sink_idle_en;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] value);
        return (value == '1) ? value : value + 32'd1;
    endfunction

    task automatic clear_counters();
        for (int b = 0; b < NUM_BITS; b++) begin
            ones_cnt[b] = '0;
        end
        for (int p = 0; p < 4*NUM_BITS; p++) begin
            pair_cnt[p] = '0;
        end
        held_word = '0;
        pair_open = 1'b0;
    endtask

    // Applies one accepted item to the local counters and queues read values.
    task automatic update_counters(input t_cmd cmd);
        logic [NUM_BITS-1:0]      word;
        int                       slot;
        logic [PAIR_IDX_BITS-1:0] pair_idx;
        word = cmd.sample_word[NUM_BITS-1:0];
        case (cmd.opcode)
            OP_ACCUM: begin
                for (int b = 0; b < NUM_BITS; b++) begin
                    if (word[b]) begin
                        ones_cnt[b] = sat_inc(ones_cnt[b]);
                    end
                end
                if (!pair_open) begin
                    held_word = word;
                    pair_open = 1'b1;
                end else begin
                    for (int b = 0; b < NUM_BITS; b++) begin
                        slot = 4 * b + 2 * held_word[b] + word[b];
                        pair_cnt[slot] = sat_inc(pair_cnt[slot]);
                    end
                    pair_open = 1'b0;
                end
            end
            OP_READ: begin
                if (cmd.counter_index < NUM_BITS) begin
                    expected_reads.push_back(
                        ones_cnt[cmd.counter_index[ONES_IDX_BITS-1:0]]);
                end else if (cmd.counter_index < NUM_COUNTERS) begin
                    pair_idx = PAIR_IDX_BITS'(cmd.counter_index - NUM_BITS);
                    expected_reads.push_back(pair_cnt[pair_idx]);
                end else begin
                    expected_reads.push_back('0);
                end
            end
            OP_CLEAR: begin
                clear_counters();
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic send_cmd(input t_cmd cmd);
        int gap;
        if (send_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                cmd_if.valid         <= 1'b0;
                cmd_if.opcode        <= OPCODE_BITS'($urandom_range(0, 3));
                cmd_if.sample_word   <= $urandom();
                cmd_if.counter_index <= INDEX_BITS'($urandom_range(0, 255));
                @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        cmd_if.valid         <= 1'b1;
        cmd_if.opcode        <= cmd.opcode;
        cmd_if.sample_word   <= cmd.sample_word;
        cmd_if.counter_index <= cmd.counter_index;
        @(posedge i_clk);
        while (!cmd_if.ready) begin
            @(posedge i_clk);
        end
        update_counters(cmd);
    endtask

    function automatic t_cmd make_cmd(input logic [OPCODE_BITS-1:0] opcode,
                                      input logic [SAMPLE_BITS-1:0] word,
                                      input logic [INDEX_BITS-1:0]  index);
        t_cmd cmd;
        cmd.opcode        = opcode;
        cmd.sample_word   = word;
        cmd.counter_index = index;
        return cmd;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_word();
        case ($urandom_range(0, 6))
            0:       return '1;
            1:       return '0;
            2:       return 32'd1 << $urandom_range(0, 31);
            3:       return ~(32'd1 << $urandom_range(0, 31));
            4:       return $urandom() & $urandom();
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [INDEX_BITS-1:0] random_any_index();
        return INDEX_BITS'($urandom_range(0, 255));
    endfunction

    // Most reads hit a real counter; some land past the last one.
    function automatic logic [INDEX_BITS-1:0] random_index();
        if ($urandom_range(0, 9) == 0) begin
            return INDEX_BITS'($urandom_range(NUM_COUNTERS, 255));
        end
        return INDEX_BITS'($urandom_range(0, NUM_COUNTERS - 1));
    endfunction

    task automatic test_directed();
        send_cmd(make_cmd(OP_READ, '0, 8'd0));
        send_cmd(make_cmd(OP_READ, '0, 8'd159));
        send_cmd(make_cmd(OP_ACCUM, 32'hFFFF_FFFF, '0));
        send_cmd(make_cmd(OP_ACCUM, 32'h0000_0000, '0));
        send_cmd(make_cmd(OP_READ, '0, 8'd31));
        send_cmd(make_cmd(OP_READ, '0, 8'd34));
        // An odd word stays held until the next accumulate closes the pair.
        send_cmd(make_cmd(OP_ACCUM, 32'hA5A5_A5A5, '0));
        send_cmd(make_cmd(OP_READ, '0, 8'd35));
        send_cmd(make_cmd(OP_UNUSED, 32'hFFFF_FFFF, 8'd0));
        send_cmd(make_cmd(OP_ACCUM, 32'h5A5A_5A5A, '0));
        send_cmd(make_cmd(OP_READ, '0, 8'd33));
        send_cmd(make_cmd(OP_READ, '0, 8'd38));
        send_cmd(make_cmd(OP_READ, '0, 8'd160));
        send_cmd(make_cmd(OP_READ, '0, 8'd255));
        // A clear throws away a held odd word as well as the counts.
        send_cmd(make_cmd(OP_ACCUM, 32'h8000_0001, '0));
        send_cmd(make_cmd(OP_CLEAR, 32'hFFFF_FFFF, 8'd0));
        send_cmd(make_cmd(OP_READ, '0, 8'd0));
        send_cmd(make_cmd(OP_ACCUM, 32'h0000_FFFF, '0));
        send_cmd(make_cmd(OP_ACCUM, 32'hFFFF_0000, '0));
        send_cmd(make_cmd(OP_READ, '0, 8'd33));
        send_cmd(make_cmd(OP_READ, '0, 8'd158));
        send_cmd(make_cmd(OP_READ, '0, 8'd128));
    endtask

    // Pairs of accumulates followed by a few reads, with some odd words,
    // clears and unused codes mixed in.
    task automatic test_random_stream(input int num_items);
        int sent;
        int pairs;
        int reads;
        sent = 0;
        while (sent < num_items) begin
            pairs = $urandom_range(1, 6);
            repeat (2 * pairs) begin
                send_cmd(make_cmd(OP_ACCUM, random_word(), random_any_index()));
                sent++;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_cmd(make_cmd(OP_ACCUM, random_word(), random_any_index()));
                sent++;
            end
            reads = $urandom_range(1, 4);
            repeat (reads) begin
                send_cmd(make_cmd(OP_READ, $urandom(), random_index()));
                sent++;
            end
            if ($urandom_range(0, 24) == 0) begin
                send_cmd(make_cmd(OP_CLEAR, $urandom(), random_any_index()));
                sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
                send_cmd(make_cmd(OP_UNUSED, $urandom(), random_any_index()));
            end
        end
    endtask

    // The sink stops taking results while reads keep coming, so the read
    // stages fill and the command input stalls.
    task automatic test_read_backpressure();
        sink_hold_cycles = 300;
        repeat (30) begin
            send_cmd(make_cmd(OP_READ, $urandom(), random_index()));
            send_cmd(make_cmd(OP_ACCUM, random_word(), '0));
        end
    endtask

    task automatic test_back_to_back();
        send_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random_stream(430);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rd_if.valid && rd_if.ready) begin
            if (expected_reads.size() == 0) begin
                report_mismatch($sformatf("read result 0x%08h with none expected",
                                          rd_if.read_value));
            end else begin
                want_value = expected_reads.pop_front();
                if (rd_if.read_value !== want_value) begin
                    report_mismatch($sformatf("read_value 0x%08h, expected 0x%08h",
                                              rd_if.read_value, want_value));
                end
            end
        end
    end

    initial begin : sink_pacing
        int stall_left;
        stall_left  = 0;
        rd_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                rd_if.ready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                rd_if.ready <= 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                rd_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end else begin
                rd_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        fail_count           = 0;
        sink_hold_cycles     = 0;
        send_idle_en         = 1'b1;
        sink_idle_en         = 1'b1;
        i_rst_n              = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.opcode        = OP_ACCUM;
        cmd_if.sample_word   = '0;
        cmd_if.counter_index = '0;
        clear_counters();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_stream(560);
        test_read_backpressure();
        test_random_stream(340);
        test_back_to_back();

        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (expected_reads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/bfsc_pkg.sv
src/bfsc_if.sv
src/bfsc_counter_bank.sv
src/bitwise_frequency_serial_counter_top.sv
sim/bitwise_frequency_serial_counter_top_tb.sv
